[sv/spq_pkg.sv]
// shared types and codes of the sorted priority queue
`timescale 1ns / 1ps

package spq_pkg;

    // field widths
    localparam int unsigned CmdW   = 2;
    localparam int unsigned ValueW = 32;
    localparam int unsigned PrioW  = 16;
    localparam int unsigned StatW  = 2;
    localparam int unsigned HeldW  = 5;

    // command codes
    localparam logic [CmdW-1:0] CMD_ENQUEUE = 2'd0;
    localparam logic [CmdW-1:0] CMD_DEQUEUE = 2'd1;
    localparam logic [CmdW-1:0] CMD_PEEK    = 2'd2;

    // status codes
    localparam logic [StatW-1:0] ST_OK    = 2'd0;
    localparam logic [StatW-1:0] ST_EMPTY = 2'd1;
    localparam logic [StatW-1:0] ST_FULL  = 2'd2;

    // commands from the controller to the datapath
    typedef struct packed {
        logic             insert;     // insert the new entry at its place
        logic             remove;     // drop the head entry
        logic             load;       // capture a result into the output register
        logic             take_head;  // result carries the head entry's data
        logic [StatW-1:0] status;     // status code of this result
    } t_dp_ctrl;

    // status from the datapath to the controller
    typedef struct packed {
        logic empty;
        logic full;
    } t_dp_stat;

endpackage

[sv/spq_if.sv]
// handshake interfaces for the command and response channels
`timescale 1ns / 1ps

interface spq_cmd_if;
    logic                               valid;
    logic                               ready;
    logic [spq_pkg::CmdW-1:0]           command;
    logic signed [spq_pkg::ValueW-1:0]  item_value;
    logic [spq_pkg::PrioW-1:0]          item_priority;

    modport source (output valid, output command, output item_value,
                    output item_priority, input ready);
    modport sink   (input valid, input command, input item_value,
                    input item_priority, output ready);
endinterface

interface spq_rsp_if;
    logic                               valid;
    logic                               ready;
    logic signed [spq_pkg::ValueW-1:0]  head_value;
    logic [spq_pkg::StatW-1:0]          status;
    logic [spq_pkg::HeldW-1:0]          entries_held;

    modport source (output valid, output head_value, output status,
                    output entries_held, input ready);
    modport sink   (input valid, input head_value, input status,
                    input entries_held, output ready);
endinterface

[sv/spq_ctrl.sv]
// controller: handshake state machine and command decode
`timescale 1ns / 1ps

module spq_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic [spq_pkg::CmdW-1:0]  i_command,
    output logic                      o_in_ready,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    input  spq_pkg::t_dp_stat         i_stat,
    output spq_pkg::t_dp_ctrl         o_ctrl
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,   // output register free
        S_HOLD = 2'b10    // result waiting in the output register
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    // a new command enters when the output register is free or being emptied
    assign o_in_ready  = (r_state == S_IDLE) || i_out_ready;
    assign o_out_valid = (r_state == S_HOLD);
    assign accept      = i_in_valid && o_in_ready;

    // state transition
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_HOLD;
            end
            S_HOLD: begin
                if (!accept && i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // command decode into datapath controls
    always_comb begin
        o_ctrl           = '0;
        o_ctrl.load      = accept;
        o_ctrl.status    = spq_pkg::ST_OK;
        if (accept) begin
            case (i_command)
                spq_pkg::CMD_ENQUEUE: begin
                    if (i_stat.full) begin
                        o_ctrl.status = spq_pkg::ST_FULL;
                    end else begin
                        o_ctrl.insert = 1'b1;
                    end
                end
                spq_pkg::CMD_DEQUEUE: begin
                    if (i_stat.empty) begin
                        o_ctrl.status = spq_pkg::ST_EMPTY;
                    end else begin
                        o_ctrl.remove    = 1'b1;
                        o_ctrl.take_head = 1'b1;
                    end
                end
                spq_pkg::CMD_PEEK: begin
                    if (i_stat.empty) begin
                        o_ctrl.status = spq_pkg::ST_EMPTY;
                    end else begin
                        o_ctrl.take_head = 1'b1;
                    end
                end
                default: o_ctrl.status = spq_pkg::ST_OK;
            endcase
        end
    end

    // never insert and remove together
    a_one_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ctrl.insert && o_ctrl.remove))
        else $error("insert and remove in the same cycle");

    // no insert into a full store
    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctrl.insert |-> !i_stat.full)
        else $error("insert while full");

    // no head taken from an empty store
    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctrl.take_head |-> !i_stat.empty)
        else $error("head taken while empty");

endmodule

[sv/spq_dp.sv]
// datapath: sorted register cells, entry count and result register
`timescale 1ns / 1ps

module spq_dp #(
    parameter int unsigned DEPTH = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  spq_pkg::t_dp_ctrl                  i_ctrl,
    input  logic signed [spq_pkg::ValueW-1:0]  i_item_value,
    input  logic [spq_pkg::PrioW-1:0]          i_item_priority,
    output spq_pkg::t_dp_stat                  o_stat,
    output logic signed [spq_pkg::ValueW-1:0]  o_head_value,
    output logic [spq_pkg::StatW-1:0]          o_status,
    output logic [spq_pkg::HeldW-1:0]          o_entries_held
);

    localparam int unsigned CntW = $clog2(DEPTH + 1);

    logic signed [spq_pkg::ValueW-1:0] r_val [DEPTH];
    logic [spq_pkg::PrioW-1:0]         r_pri [DEPTH];
    logic signed [spq_pkg::ValueW-1:0] n_val [DEPTH];
    logic [spq_pkg::PrioW-1:0]         n_pri [DEPTH];
    logic [CntW-1:0]                   r_count;
    logic [CntW-1:0]                   n_count;
    logic [DEPTH-1:0]                  stay;      // cell holds an entry that stays ahead
    logic [CntW+spq_pkg::HeldW-1:0]    held_ext;

    logic signed [spq_pkg::ValueW-1:0] r_head_value;
    logic [spq_pkg::StatW-1:0]         r_status;
    logic [spq_pkg::HeldW-1:0]         r_entries_held;

    // store status
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == CntW'(DEPTH));

    // one cell per entry, each choosing among keep, new entry and its neighbors
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic prev_stay;

        // occupied and at least as urgent as the new entry
        assign stay[g] = (r_count > CntW'(g)) && (r_pri[g] >= i_item_priority);

        if (g == 0) begin : g_first
            assign prev_stay = 1'b1;
        end else begin : g_rest
            assign prev_stay = stay[g-1];
        end

        always_comb begin
            n_val[g] = r_val[g];
            n_pri[g] = r_pri[g];
            if (i_ctrl.insert && !stay[g]) begin
                if (prev_stay) begin
                    n_val[g] = i_item_value;
                    n_pri[g] = i_item_priority;
                end else begin
                    n_val[g] = r_val[(g > 0) ? g - 1 : 0];
                    n_pri[g] = r_pri[(g > 0) ? g - 1 : 0];
                end
            end else if (i_ctrl.remove && (g < DEPTH - 1)) begin
                n_val[g] = r_val[(g < DEPTH - 1) ? g + 1 : g];
                n_pri[g] = r_pri[(g < DEPTH - 1) ? g + 1 : g];
            end
        end

        always_ff @(posedge i_clk) begin
            r_val[g] <= n_val[g];
            r_pri[g] <= n_pri[g];
        end
    end

    // entry count
    always_comb begin
        n_count = r_count;
        if (i_ctrl.insert) begin
            n_count = r_count + CntW'(1);
        end else if (i_ctrl.remove) begin
            n_count = r_count - CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // count after the command, low bits only
    assign held_ext = {{spq_pkg::HeldW{1'b0}}, n_count};

    // result register
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_head_value   <= i_ctrl.take_head ? r_val[0] : '0;
            r_status       <= i_ctrl.status;
            r_entries_held <= held_ext[spq_pkg::HeldW-1:0];
        end
    end

    assign o_head_value   = r_head_value;
    assign o_status       = r_status;
    assign o_entries_held = r_entries_held;

    // count stays within the store
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(DEPTH))
        else $error("entry count beyond depth");

    // an insert adds exactly one entry
    a_count_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.insert |=> (!$past(i_rst_n) || r_count == $past(r_count) + CntW'(1)))
        else $error("insert did not add one entry");

    // a removal drops exactly one entry
    a_count_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.remove |=> (!$past(i_rst_n) || r_count == $past(r_count) - CntW'(1)))
        else $error("remove did not drop one entry");

endmodule

[sv/sorted_priority_queue.sv]
// sorted priority queue top level: controller and cell datapath
//
//  channel  dir  handshake      payload
//  i_cmd    in   valid / ready  command, item_value, item_priority
//  o_rsp    out  valid / ready  head_value, status, entries_held
//
// one command per cycle while o_rsp is not stalled; each transfer updates the cells in the same cycle
// and its result appears in the output register on the next cycle.
// the rate is set by the parallel compare and shift across all DEPTH cells.
// a new command is taken while a result waits, if that result leaves that cycle.
// a stalled response holds the command channel until o_rsp.ready rises.
// synchronous active-low reset empties the queue; no clearing pass is needed.
`timescale 1ns / 1ps

module sorted_priority_queue #(
    parameter int unsigned DEPTH = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    spq_cmd_if.sink      i_cmd,
    spq_rsp_if.source    o_rsp
);

    spq_pkg::t_dp_ctrl ctrl;
    spq_pkg::t_dp_stat stat;

    // handshake and command decode
    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd.valid),
        .i_command   (i_cmd.command),
        .o_in_ready  (i_cmd.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_stat      (stat),
        .o_ctrl      (ctrl)
    );

    // sorted cells and result register
    spq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctrl          (ctrl),
        .i_item_value    (i_cmd.item_value),
        .i_item_priority (i_cmd.item_priority),
        .o_stat          (stat),
        .o_head_value    (o_rsp.head_value),
        .o_status        (o_rsp.status),
        .o_entries_held  (o_rsp.entries_held)
    );

endmodule

[test/spq_checker.sv]
// checker for the sorted priority queue: tracks transfers, predicts results and compares
`timescale 1ns / 1ps

module spq_checker #(
    parameter int unsigned DEPTH = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    spq_cmd_if   i_cmd,
    spq_rsp_if   i_rsp,
    output int   o_fail_count,
    output int   o_pending
);

    // one stored entry of the predicted queue
    typedef struct packed {
        logic signed [spq_pkg::ValueW-1:0] value;
        logic [spq_pkg::PrioW-1:0]         prio;
    } t_entry;

    // one result as the response channel carries it
    typedef struct packed {
        logic signed [spq_pkg::ValueW-1:0] head_value;
        logic [spq_pkg::StatW-1:0]         status;
        logic [spq_pkg::HeldW-1:0]         entries_held;
    } t_queue_result;

    t_entry        held_entries[$];
    t_queue_result awaited_results[$];
    t_queue_result oldest;
    int            fail_total = 0;

    assign o_fail_count = fail_total;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        fail_total++;
    endtask

    // apply one command to the predicted store and return the result it gives
    function automatic t_queue_result apply_command(
        input logic [spq_pkg::CmdW-1:0]          cmd,
        input logic signed [spq_pkg::ValueW-1:0] value,
        input logic [spq_pkg::PrioW-1:0]         prio
    );
        t_queue_result res;
        t_entry        ent;
        int            pos;
        res.head_value = '0;
        res.status     = spq_pkg::ST_OK;
        case (cmd)
            spq_pkg::CMD_ENQUEUE: begin
                if (held_entries.size() >= DEPTH) begin
                    res.status = spq_pkg::ST_FULL;
                end else begin
                    // new entry goes behind every entry of equal or higher priority
                    pos = 0;
                    while (pos < held_entries.size() && held_entries[pos].prio >= prio)
                        pos++;
                    ent.value = value;
                    ent.prio  = prio;
                    held_entries.insert(pos, ent);
                end
            end
            spq_pkg::CMD_DEQUEUE, spq_pkg::CMD_PEEK: begin
                if (held_entries.size() == 0) begin
                    res.status = spq_pkg::ST_EMPTY;
                end else begin
                    res.head_value = held_entries[0].value;
                    if (cmd == spq_pkg::CMD_DEQUEUE)
                        void'(held_entries.pop_front());
                end
            end
            default: ;
        endcase
        res.entries_held = spq_pkg::HeldW'(held_entries.size());
        return res;
    endfunction

    // response transfers are checked before a same-cycle command is predicted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held_entries.delete();
            awaited_results.delete();
            o_pending <= 0;
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch("response with nothing awaited", i_rsp.head_value, '0);
                end else begin
                    oldest = awaited_results.pop_front();
                    if (i_rsp.head_value !== oldest.head_value)
                        report_mismatch("head_value", i_rsp.head_value, oldest.head_value);
                    if (i_rsp.status !== oldest.status)
                        report_mismatch("status", 32'(i_rsp.status), 32'(oldest.status));
                    if (i_rsp.entries_held !== oldest.entries_held)
                        report_mismatch("entries_held", 32'(i_rsp.entries_held),
                                        32'(oldest.entries_held));
                end
            end
            if (i_cmd.valid && i_cmd.ready)
                awaited_results.push_back(apply_command(i_cmd.command, i_cmd.item_value,
                                                        i_cmd.item_priority));
            o_pending <= awaited_results.size();
        end
    end

endmodule

[test/tb.sv]
// testbench top for the sorted priority queue: stimulus, idling and verdict
`timescale 1ns / 1ps

module tb;

    localparam int unsigned DEPTH       = 16;
    localparam int          CYCLE_LIMIT = 200000;
    localparam int          BLOCK_LEN   = 60;
    localparam int          NUM_BLOCKS  = 15;

    // command code that the block must treat as a no-op
    localparam logic [spq_pkg::CmdW-1:0] CMD_UNUSED = 2'd3;

    logic clk = 1'b0;
    logic rst_n;
    int   fail_count;
    int   pending_count;
    int   cycle_count = 0;
    int   send_gap_pct = 0;
    int   stall_pct = 0;

    spq_cmd_if cmd_if ();
    spq_rsp_if rsp_if ();

    sorted_priority_queue #(.DEPTH(DEPTH)) u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cmd   (cmd_if),
        .o_rsp   (rsp_if)
    );

    spq_checker #(.DEPTH(DEPTH)) u_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cmd        (cmd_if),
        .i_rsp        (rsp_if),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    always #5 clk = ~clk;

    // run limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // response side stalls in random bursts
    initial begin
        rsp_if.ready <= 1'b1;
        forever begin
            @(posedge clk);
            if ($urandom_range(99) < stall_pct) begin
                rsp_if.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // one command transfer, with an optional idle burst in front
    task automatic send_command(input logic [spq_pkg::CmdW-1:0] cmd,
                                input logic signed [spq_pkg::ValueW-1:0] value,
                                input logic [spq_pkg::PrioW-1:0] prio);
        if ($urandom_range(99) < send_gap_pct) begin
            cmd_if.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        cmd_if.valid         <= 1'b1;
        cmd_if.command       <= cmd;
        cmd_if.item_value    <= value;
        cmd_if.item_priority <= prio;
        @(posedge clk);
        while (!cmd_if.ready) @(posedge clk);
    endtask

    // hold off until every awaited result has come back
    task automatic wait_drained();
        cmd_if.valid <= 1'b0;
        do @(posedge clk); while (pending_count != 0);
    endtask

    // priorities mostly from a narrow range so that ties are common
    function automatic logic [spq_pkg::PrioW-1:0] pick_priority();
        int sel;
        sel = $urandom_range(9);
        if (sel < 6)
            return spq_pkg::PrioW'($urandom_range(0, 7));
        else if (sel == 6)
            return $urandom_range(1) ? '1 : '0;
        else
            return spq_pkg::PrioW'($urandom);
    endfunction

    function automatic logic signed [spq_pkg::ValueW-1:0] pick_value();
        int sel;
        sel = $urandom_range(19);
        if (sel == 0)
            return {1'b1, {(spq_pkg::ValueW-1){1'b0}}};
        else if (sel == 1)
            return {1'b0, {(spq_pkg::ValueW-1){1'b1}}};
        else
            return spq_pkg::ValueW'($urandom);
    endfunction

    // random command with a given share of enqueues
    function automatic logic [spq_pkg::CmdW-1:0] pick_command(input int enq_pct);
        int sel;
        sel = $urandom_range(99);
        if (sel == 0)
            return CMD_UNUSED;
        else if (sel <= enq_pct)
            return spq_pkg::CMD_ENQUEUE;
        else if ($urandom_range(9) < 7)
            return spq_pkg::CMD_DEQUEUE;
        else
            return spq_pkg::CMD_PEEK;
    endfunction

    initial begin
        int enq_pct;
        cmd_if.valid         <= 1'b0;
        cmd_if.command       <= spq_pkg::CMD_ENQUEUE;
        cmd_if.item_value    <= '0;
        cmd_if.item_priority <= '0;
        rst_n                <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty cases, extremes, ties, fill to full and one refusal
        send_gap_pct = 20;
        stall_pct    = 20;
        send_command(spq_pkg::CMD_PEEK, '0, '0);
        send_command(spq_pkg::CMD_DEQUEUE, '0, '0);
        send_command(CMD_UNUSED, 32'sd5, 16'd5);
        send_command(spq_pkg::CMD_ENQUEUE, {1'b1, {(spq_pkg::ValueW-1){1'b0}}}, '0);
        send_command(spq_pkg::CMD_ENQUEUE, {1'b0, {(spq_pkg::ValueW-1){1'b1}}}, '1);
        send_command(spq_pkg::CMD_ENQUEUE, '1, '1);
        send_command(spq_pkg::CMD_PEEK, '0, '0);
        for (int k = 0; k < DEPTH - 3; k++)
            send_command(spq_pkg::CMD_ENQUEUE, spq_pkg::ValueW'($urandom),
                         spq_pkg::PrioW'(k % 4));
        send_command(spq_pkg::CMD_ENQUEUE, 32'sd123, '1);
        send_command(CMD_UNUSED, '1, '1);
        send_command(spq_pkg::CMD_DEQUEUE, '0, '0);
        send_command(spq_pkg::CMD_DEQUEUE, '0, '0);
        wait_drained();

        // random blocks alternate between filling, draining and mixed traffic
        for (int blk = 0; blk < NUM_BLOCKS; blk++) begin
            case (blk % 3)
                0:       enq_pct = 75;
                1:       enq_pct = 25;
                default: enq_pct = 50;
            endcase
            if (blk >= NUM_BLOCKS - 2 || blk % 4 == 3) begin
                send_gap_pct = 0;
                stall_pct    = 0;
            end else begin
                send_gap_pct = 30;
                stall_pct    = 30;
            end
            if (blk == NUM_BLOCKS / 2)
                wait_drained();
            for (int n = 0; n < BLOCK_LEN; n++)
                send_command(pick_command(enq_pct), pick_value(), pick_priority());
        end

        wait_drained();
        repeat (4) @(posedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[files.f]
sv/spq_pkg.sv
sv/spq_if.sv
sv/spq_ctrl.sv
sv/spq_dp.sv
sv/sorted_priority_queue.sv
test/spq_checker.sv
test/tb.sv
